// File: hdl/sst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg - step sequencer tick unit package
// Shared sizes, event codes, word types and constant tables.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int NUM_STEPS      = 8;
  localparam int TICKS_PER_STEP = 128;

  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam int TICK_W    = $clog2(TICKS_PER_STEP);
  localparam int NOTE_W    = 7;
  localparam int PERIOD_W  = 16;
  localparam int DIV_W     = 4;
  localparam int DIV_CNT_W = $clog2(PERIOD_W);
  localparam int CMP_W     = (TICK_W > NOTE_W) ? TICK_W : NOTE_W;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ON   = 2'd1;
  localparam logic [1:0] EV_OFF  = 2'd2;

  localparam logic [NOTE_W-1:0] VEL_DEFAULT = 7'd100;
  localparam logic [NOTE_W-1:0] PITCH_MAX   = 7'd60;
  localparam logic [NOTE_W-1:0] PITCH_BASE  = 7'd20;

  typedef struct packed {
    logic       req_type;
    logic       record_enable;
    logic [9:0] knob_sample;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          note_event;
    logic [NOTE_W-1:0]   event_note;
    logic [NOTE_W-1:0]   event_velocity;
    logic [PERIOD_W-1:0] tone_period;
    logic [2:0]          step_index;
    logic                tone_gate;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [NOTE_W-1:0] step_length_f(input int unsigned i);
    return NOTE_W'(127 >> (i & 3));
  endfunction

  function automatic logic [NOTE_W-1:0] step_pitch_init_f(input int unsigned i);
    return NOTE_W'((69 + i + (i & 1)) & 127);
  endfunction

  function automatic logic [PERIOD_W-1:0] period_base_f(input logic [3:0] semi);
    logic [PERIOD_W-1:0] p;
    unique case (semi)
      4'd0:    p = 16'd36363;
      4'd1:    p = 16'd34334;
      4'd2:    p = 16'd32388;
      4'd3:    p = 16'd30592;
      4'd4:    p = 16'd28880;
      4'd5:    p = 16'd27257;
      4'd6:    p = 16'd25723;
      4'd7:    p = 16'd24279;
      4'd8:    p = 16'd22922;
      4'd9:    p = 16'd21621;
      4'd10:   p = 16'd20408;
      4'd11:   p = 16'd19253;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sst_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_div - radix-2 restoring divider
// Divides the 16-bit period base by a small divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sst_div
  import sst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [PERIOD_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]    divisor,
  output div_stat_t                stat,
  output logic      [PERIOD_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [PERIOD_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[PERIOD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt = {quo_r[PERIOD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(PERIOD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

// File: hdl/step_sequencer_tick_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// step_sequencer_tick_unit - tick-driven eight-step note sequencer
// Advances a tick counter and step pointer, reports note events and tone period.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / in_word) takes one tick word: a
//   sequence tick or a drum tick, with record flag and knob sample
//   output channel (out_valid / out_stall / out_word) returns exactly one
//   result word per tick: note event, note, velocity, tone period, step, gate
//   path: a drum tick or a sequence tick without step wrap goes from accept
//   through EVAL and DONE to out_valid; a tick that wraps to a new step also
//   passes PLAY and DIV, waiting for the one-bit-per-cycle period divider
//   the block holds in_stall high from accept until its result is loaded
//   into the output register, so one tick is in work at a time; a new tick
//   is accepted while the previous result still waits in the output register
//   receiver stall: a finished result waits in the work engine until the
//   output register is free, in_stall stays high meanwhile
//   reset: synchronous, rst_n low; step pitches, gates, counter, step
//   pointer and held period return to their power-up values at once
// ----------------------------------------------------------------------------
module step_sequencer_tick_unit
  import sst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_PLAY = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_r, state_nxt;
  in_word_t            req_r, req_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [STEP_W-1:0]   cur_r, cur_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [NOTE_W-1:0]   pitch_r [NUM_STEPS];
  logic [NOTE_W-1:0]   pitch_nxt [NUM_STEPS];
  logic [NUM_STEPS-1:0] gate_r, gate_nxt;
  logic [1:0]          ev_r, ev_nxt;
  logic [NOTE_W-1:0]   note_r, note_nxt;
  logic [NOTE_W-1:0]   vel_r, vel_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic [TICK_W:0]     tick_inc;
  logic [TICK_W-1:0]   tick_new;
  logic [STEP_W-1:0]   cur_inc;
  logic [NOTE_W-1:0]   cur_pitch;
  logic [NOTE_W-1:0]   knob_note;
  logic [NOTE_W-1:0]   rec_note;
  logic [NOTE_W-1:0]   play_note;
  logic [12:0]         note_x43;
  logic [DIV_W-1:0]    octave;
  logic [3:0]          semi;
  logic [TICK_W:0]     tick_p1;
  logic [5:0]          drum_fac;
  logic [TICK_W+6:0]   drum_prod;
  logic                accept;
  logic                div_start;
  div_stat_t           div_stat;
  logic [PERIOD_W-1:0] div_quo;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;

  assign tick_inc  = (TICK_W+1)'(tick_r) + 1'b1;
  assign tick_new  = (tick_inc == (TICK_W+1)'(TICKS_PER_STEP)) ? '0 : tick_inc[TICK_W-1:0];
  assign cur_inc   = (cur_r == STEP_W'(NUM_STEPS - 1)) ? '0 : cur_r + 1'b1;
  assign cur_pitch = pitch_r[cur_r];

  assign knob_note = NOTE_W'(req_r.knob_sample[9:5]) + PITCH_BASE;
  assign rec_note  = (knob_note < PITCH_MAX) ? knob_note : PITCH_MAX;
  assign play_note = req_r.record_enable ? rec_note : cur_pitch;

  // note / 12 by reciprocal, exact for 7-bit notes
  assign note_x43  = 13'(play_note) * 13'd43;
  assign octave    = note_x43[12:9];
  assign semi      = 4'(play_note - NOTE_W'(octave) * 7'd12);

  assign tick_p1   = (TICK_W+1)'(tick_r) + 1'b1;
  assign drum_fac  = 6'd10 + 6'd10 * (6'(cur_r) & 6'd3);
  assign drum_prod = (TICK_W+7)'(tick_p1) * (TICK_W+7)'(drum_fac);

  assign div_start = state_r == S_PLAY;

  sst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (period_base_f(semi)),
    .divisor  (octave + 1'b1),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    tick_nxt      = tick_r;
    cur_nxt       = cur_r;
    period_nxt    = period_r;
    pitch_nxt     = pitch_r;
    gate_nxt      = gate_r;
    ev_nxt        = ev_r;
    note_nxt      = note_r;
    vel_nxt       = vel_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_word;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ev_nxt    = EV_NONE;
        note_nxt  = '0;
        vel_nxt   = '0;
        state_nxt = S_DONE;
        if (req_r.req_type) begin
          period_nxt = PERIOD_W'({drum_prod, 1'b0});
        end else begin
          tick_nxt = tick_new;
          if (CMP_W'(tick_new) == CMP_W'(step_length_f(int'(cur_r)))) begin
            gate_nxt[cur_r] = 1'b0;
            ev_nxt          = EV_OFF;
            note_nxt        = cur_pitch;
          end
          if (tick_new == '0) begin
            cur_nxt   = cur_inc;
            state_nxt = S_PLAY;
          end
        end
      end
      S_PLAY: begin
        if (req_r.record_enable) begin
          pitch_nxt[cur_r] = rec_note;
        end
        gate_nxt[cur_r] = 1'b1;
        ev_nxt          = EV_ON;
        note_nxt        = play_note;
        vel_nxt         = VEL_DEFAULT;
        state_nxt       = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          period_nxt = div_quo;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.note_event     = ev_r;
          out_word_nxt.event_note     = note_r;
          out_word_nxt.event_velocity = vel_r;
          out_word_nxt.tone_period    = period_r;
          out_word_nxt.step_index     = 3'(cur_r);
          out_word_nxt.tone_gate      = gate_r[cur_r];
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      cur_r       <= '0;
      period_r    <= '0;
      gate_r      <= '1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STEPS; i++) begin
        pitch_r[i] <= step_pitch_init_f(i);
      end
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      cur_r       <= cur_nxt;
      period_r    <= period_nxt;
      gate_r      <= gate_nxt;
      out_valid_r <= out_valid_nxt;
      pitch_r     <= pitch_nxt;
    end
    req_r      <= req_nxt;
    ev_r       <= ev_nxt;
    note_r     <= note_nxt;
    vel_r      <= vel_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == S_DIV)
    else $error("divider busy outside divide state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EVAL)
    else $error("accepted word did not start evaluation");

  a_on_gate_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.note_event == EV_ON |-> out_word_r.tone_gate)
    else $error("note-on reported with gate low");

  a_vel_only_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.note_event != EV_ON |-> out_word_r.event_velocity == '0)
    else $error("velocity reported without note-on");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.note_event == EV_NONE || out_word_r.note_event == EV_ON
                    || out_word_r.note_event == EV_OFF)
    else $error("bad note event code");

endmodule
`default_nettype wire

// File: tb/step_sequencer_tick_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_sequencer_tick_unit_test - self-checking bench for the tick sequencer
// Sends directed and random sequence and drum ticks, predicts each result
// word from a local model of the step memory, and compares the words in order.
// ----------------------------------------------------------------------------
module step_sequencer_tick_unit_test;
  import sst_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_HALF  = 147;
  localparam int SETTLE_TICKS = 40;

  // semitone periods, index 0 in the low bits
  localparam logic [11:0][PERIOD_W-1:0] SEMITONE_PERIOD = {
    16'd19253, 16'd20408, 16'd21621, 16'd22922, 16'd24279, 16'd25723,
    16'd27257, 16'd28880, 16'd30592, 16'd32388, 16'd34334, 16'd36363
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  tick_queue[$];
  out_word_t awaited_reports[$];
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // local copy of the sequencer state
  logic [NOTE_W-1:0]   seq_pitch [NUM_STEPS];
  logic [NOTE_W-1:0]   seq_length [NUM_STEPS];
  logic [NOTE_W-1:0]   seq_velocity [NUM_STEPS];
  logic                seq_gate [NUM_STEPS];
  logic [TICK_W-1:0]   seq_tick;
  logic [2:0]          seq_step;
  logic [PERIOD_W-1:0] held_period;

  step_sequencer_tick_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic reset_sequencer_model();
    for (int i = 0; i < NUM_STEPS; i++) begin
      seq_pitch[i]    = NOTE_W'((69 + i + (i & 1)) & 127);
      seq_length[i]   = NOTE_W'(127 >> (i & 3));
      seq_velocity[i] = VEL_DEFAULT;
      seq_gate[i]     = 1'b1;
    end
    seq_tick    = '0;
    seq_step    = '0;
    held_period = '0;
  endtask

  function automatic logic [PERIOD_W-1:0] pitch_to_period(logic [NOTE_W-1:0] pitch);
    int unsigned base;
    base = 32'(SEMITONE_PERIOD[int'(pitch) % 12]);
    return PERIOD_W'(base / (1 + int'(pitch) / 12));
  endfunction

  function automatic out_word_t advance_sequencer(in_word_t w);
    out_word_t         r;
    logic [2:0]        step;
    logic [NOTE_W-1:0] rec_pitch;
    r = '0;
    step = seq_step;
    if (w.req_type) begin
      held_period = PERIOD_W'(((int'(seq_tick) + 1) * (10 + 10 * (int'(step) & 3))) << 1);
    end else begin
      seq_tick = (int'(seq_tick) == TICKS_PER_STEP - 1) ? '0 : seq_tick + 1'b1;
      if (NOTE_W'(seq_tick) == seq_length[step]) begin
        seq_gate[step]   = 1'b0;
        r.note_event     = EV_OFF;
        r.event_note     = seq_pitch[step];
        r.event_velocity = '0;
      end
      if (seq_tick == '0) begin
        step = (int'(step) == NUM_STEPS - 1) ? '0 : step + 1'b1;
        if (w.record_enable) begin
          rec_pitch = NOTE_W'(w.knob_sample >> 5) + PITCH_BASE;
          seq_pitch[step] = (rec_pitch < PITCH_MAX) ? rec_pitch : PITCH_MAX;
        end
        seq_gate[step]   = 1'b1;
        held_period      = pitch_to_period(seq_pitch[step]);
        r.note_event     = EV_ON;
        r.event_note     = seq_pitch[step];
        r.event_velocity = seq_velocity[step];
      end
      seq_step = step;
    end
    r.tone_period = held_period;
    r.step_index  = step;
    r.tone_gate   = seq_gate[step];
    return r;
  endfunction

  function automatic in_word_t random_tick();
    in_word_t w;
    w.req_type      = ($urandom_range(0, 99) < 2);
    w.record_enable = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       w.knob_sample = '0;
      1:       w.knob_sample = '1;
      default: w.knob_sample = 10'($urandom_range(0, 1023));
    endcase
    return w;
  endfunction

  task automatic queue_tick(logic req, logic rec, logic [9:0] knob);
    in_word_t w;
    w.req_type      = req;
    w.record_enable = rec;
    w.knob_sample   = knob;
    tick_queue.push_back(w);
  endtask

  task automatic drain_sequencer();
    while (tick_queue.size() != 0 || in_valid || awaited_reports.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_HALF) tick_queue.push_back(random_tick());
    // sender stays quiet until every report is back
    drain_sequencer();
    repeat (RANDOM_HALF) tick_queue.push_back(random_tick());
    drain_sequencer();
  endtask

  // driver
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && (!in_valid || in_taken)) begin
      if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_word_t want;
    out_word_t got;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      awaited_reports.push_back(advance_sequencer(in_word));
    end
    if (rst_n && out_valid && !out_stall) begin
      got = out_word;
      if (awaited_reports.size() == 0) begin
        $error("unexpected result word %h", got);
        mismatch_count++;
      end else begin
        want = awaited_reports.pop_front();
        if (got.note_event !== want.note_event) begin
          $error("note_event expected %0d actual %0d", want.note_event, got.note_event);
          mismatch_count++;
        end
        if (got.event_note !== want.event_note) begin
          $error("event_note expected %0d actual %0d", want.event_note, got.event_note);
          mismatch_count++;
        end
        if (got.event_velocity !== want.event_velocity) begin
          $error("event_velocity expected %0d actual %0d",
                 want.event_velocity, got.event_velocity);
          mismatch_count++;
        end
        if (got.tone_period !== want.tone_period) begin
          $error("tone_period expected %0d actual %0d", want.tone_period, got.tone_period);
          mismatch_count++;
        end
        if (got.step_index !== want.step_index) begin
          $error("step_index expected %0d actual %0d", want.step_index, got.step_index);
          mismatch_count++;
        end
        if (got.tone_gate !== want.tone_gate) begin
          $error("tone_gate expected %0d actual %0d", want.tone_gate, got.tone_gate);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    reset_sequencer_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: drum at reset, knob extremes, alternating bits
    send_idle_pct = 26;
    recv_idle_pct = 65;
    queue_tick(1'b1, 1'b0, 10'h000);
    queue_tick(1'b1, 1'b1, 10'h3ff);
    queue_tick(1'b0, 1'b1, 10'h3ff);
    queue_tick(1'b0, 1'b0, 10'h000);
    queue_tick(1'b0, 1'b1, 10'h000);
    queue_tick(1'b1, 1'b0, 10'h200);
    queue_tick(1'b0, 1'b1, 10'h2aa);
    queue_tick(1'b0, 1'b0, 10'h155);
    queue_tick(1'b1, 1'b1, 10'h155);
    queue_tick(1'b1, 1'b0, 10'h2aa);
    queue_tick(1'b0, 1'b1, 10'h01f);
    queue_tick(1'b0, 1'b0, 10'h3e0);
    queue_tick(1'b1, 1'b1, 10'h3e0);
    queue_tick(1'b0, 1'b0, 10'h3ff);
    queue_tick(1'b1, 1'b0, 10'h000);
    queue_tick(1'b0, 1'b1, 10'h020);
    drain_sequencer();

    run_random(26, 65);
    run_random(65, 26);
    run_random(0, 0);

    repeat (SETTLE_TICKS) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $error("%0d result words never arrived", awaited_reports.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sst_pkg.sv
hdl/sst_div.sv
hdl/step_sequencer_tick_unit.sv
tb/step_sequencer_tick_unit_test.sv
